### rtl/core/cspm_pkg.sv
// ----------------------------------------------------------------------------
// cspm_pkg
// Shared types and constants for the PI clock servo with median pre-filter.
// ----------------------------------------------------------------------------
package cspm_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 31;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_INTEGRAL   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PROP_SHIFT     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEG_SHIFT    = 2'd3;

  // register values after reset
  localparam logic [30:0] RST_STEP_THRESHOLD = 31'd100000000;
  localparam logic [29:0] RST_MAX_INTEGRAL   = 30'd100000;
  localparam logic [4:0]  RST_PROP_SHIFT     = 5'd2;
  localparam logic [4:0]  RST_INTEG_SHIFT    = 5'd7;

  localparam logic ACTION_SLEW = 1'b0;
  localparam logic ACTION_STEP = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_RM,
    ST_INS_START,
    ST_INS,
    ST_MED,
    ST_MUL,
    ST_ACC,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic capture;
    logic decide;
    logic rm_scan;
    logic ins_start;
    logic ins_scan;
    logic med_read;
    logic mul;
    logic acc;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic step;
    logic full;
    logic rm_done;
    logic ins_done;
  } sts_t;

endpackage

### rtl/core/cspm_ram.sv
// ----------------------------------------------------------------------------
// cspm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cspm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/cspm_ctrl.sv
// ----------------------------------------------------------------------------
// cspm_ctrl
// Sequencer: steps one item through check, window update and PI law.
// ----------------------------------------------------------------------------
module cspm_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  cspm_pkg::sts_t sts,
  output cspm_pkg::cmd_t cmd
);

  cspm_pkg::state_t state;
  cspm_pkg::state_t state_next;
  logic             out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= cspm_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      cspm_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = cspm_pkg::ST_CHECK;
        end
      end
      cspm_pkg::ST_CHECK: begin
        cmd.decide = 1'b1;
        if (sts.step) begin
          state_next = cspm_pkg::ST_DONE;
        end else if (sts.full) begin
          state_next = cspm_pkg::ST_RM;
        end else begin
          state_next = cspm_pkg::ST_INS_START;
        end
      end
      cspm_pkg::ST_RM: begin
        cmd.rm_scan = 1'b1;
        if (sts.rm_done) begin
          state_next = cspm_pkg::ST_INS_START;
        end
      end
      cspm_pkg::ST_INS_START: begin
        cmd.ins_start = 1'b1;
        state_next    = cspm_pkg::ST_INS;
      end
      cspm_pkg::ST_INS: begin
        cmd.ins_scan = 1'b1;
        if (sts.ins_done) begin
          state_next = cspm_pkg::ST_MED;
        end
      end
      cspm_pkg::ST_MED: begin
        cmd.med_read = 1'b1;
        state_next   = cspm_pkg::ST_MUL;
      end
      cspm_pkg::ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = cspm_pkg::ST_ACC;
      end
      cspm_pkg::ST_ACC: begin
        cmd.acc    = 1'b1;
        state_next = cspm_pkg::ST_DONE;
      end
      cspm_pkg::ST_DONE: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = cspm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = cspm_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/core/cspm_dp.sv
// ----------------------------------------------------------------------------
// cspm_dp
// Datapath: step check, median window in two RAMs, PI law and output register.
// ----------------------------------------------------------------------------
module cspm_dp #(
  parameter int WINDOW = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  cspm_pkg::cmd_t                    cmd,
  output cspm_pkg::sts_t                    sts,
  input  logic                              cfg_we,
  input  logic [cspm_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [cspm_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic signed [63:0]                meas_offset,
  input  logic [15:0]                       interval_mult,
  output logic                              action,
  output logic signed [63:0]                step_amount,
  output logic signed [31:0]                freq_adj_ppb
);

  localparam int AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CW = $clog2(WINDOW + 1);
  localparam int IW = AW + 1;

  // configuration
  logic [30:0] thr;
  logic [29:0] max_int;
  logic [4:0]  prop_sh;
  logic [4:0]  integ_sh;

  // item and state
  logic [63:0]        off;
  logic [15:0]        ivl;
  logic               step_flag;
  logic [CW-1:0]      count;
  logic [AW-1:0]      wp;
  logic signed [31:0] integral;

  // scan control
  logic [IW-1:0]      rd;
  logic               rvld;
  logic [AW-1:0]      di;
  logic               found;
  logic [IW-1:0]      rk;
  logic               ivld;
  logic [AW-1:0]      dk;

  // arithmetic
  logic signed [31:0] p;
  logic signed [48:0] prod;

  // RAM ports
  logic               s_we;
  logic [AW-1:0]      s_waddr;
  logic [31:0]        s_wdata;
  logic [AW-1:0]      s_raddr;
  logic [31:0]        srd;
  logic [31:0]        old;

  logic [63:0]        mag;
  logic               step;
  logic [31:0]        x;
  logic [CW-1:0]      c;
  logic [CW-1:0]      c1;
  logic [AW-1:0]      med_idx;
  logic               gt;
  logic signed [31:0] mi;
  logic signed [49:0] sum;
  logic signed [49:0] lim;
  logic signed [32:0] total;
  logic signed [31:0] sat;

  assign x       = off[31:0];
  assign mag     = off[63] ? (64'd0 - off) : off;
  assign step    = mag > {33'd0, thr};
  assign c       = (count == CW'(WINDOW)) ? CW'(WINDOW - 1) : count;
  assign c1      = c + CW'(1);
  assign med_idx = AW'(c1 >> 1);
  assign gt      = $signed(srd) > $signed(x);
  assign mi      = $signed(srd);
  assign sum     = 50'(integral) + 50'(prod);
  assign lim     = $signed({20'd0, max_int});
  assign total   = 33'(p) + 33'(integral);

  always_comb begin
    if (total > 33'sd2147483647) begin
      sat = 32'sh7fffffff;
    end else if (total < -33'sd2147483648) begin
      sat = 32'sh80000000;
    end else begin
      sat = 32'(total);
    end
  end

  assign sts.step     = step;
  assign sts.full     = (count == CW'(WINDOW));
  assign sts.rm_done  = cmd.rm_scan && rvld && (di == AW'(WINDOW - 1));
  assign sts.ins_done = cmd.ins_scan && ((ivld && !gt) || (!ivld && rk[IW-1]));

  // sorted window port selection
  always_comb begin
    s_we    = 1'b0;
    s_waddr = '0;
    s_wdata = x;
    if (cmd.rm_scan) begin
      s_raddr = rd[AW-1:0];
      if (rvld && found) begin
        s_we    = 1'b1;
        s_waddr = di - AW'(1);
        s_wdata = srd;
      end
    end else if (cmd.ins_scan) begin
      s_raddr = rk[AW-1:0];
      if (ivld) begin
        s_we    = 1'b1;
        s_waddr = dk + AW'(1);
        s_wdata = gt ? srd : x;
      end else if (rk[IW-1]) begin
        // everything shifted up, new value lands at the bottom
        s_we = 1'b1;
      end
    end else begin
      s_raddr = med_idx;
    end
  end

  cspm_ram #(.WIDTH(32), .DEPTH(WINDOW)) u_sorted (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (s_raddr),
    .rdata (srd)
  );

  cspm_ram #(.WIDTH(32), .DEPTH(WINDOW)) u_ring (
    .clk   (clk),
    .we    (cmd.med_read),
    .waddr (wp),
    .wdata (x),
    .raddr (wp),
    .rdata (old)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      thr      <= cspm_pkg::RST_STEP_THRESHOLD;
      max_int  <= cspm_pkg::RST_MAX_INTEGRAL;
      prop_sh  <= cspm_pkg::RST_PROP_SHIFT;
      integ_sh <= cspm_pkg::RST_INTEG_SHIFT;
    end else if (cfg_we) begin
      case (cfg_idx)
        cspm_pkg::CFG_STEP_THRESHOLD: thr      <= cfg_wdata[30:0];
        cspm_pkg::CFG_MAX_INTEGRAL:   max_int  <= cfg_wdata[29:0];
        cspm_pkg::CFG_PROP_SHIFT:     prop_sh  <= cfg_wdata[4:0];
        cspm_pkg::CFG_INTEG_SHIFT:    integ_sh <= cfg_wdata[4:0];
        default: begin
        end
      endcase
    end
  end

  // servo state
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      wp       <= '0;
      integral <= '0;
    end else begin
      if (cmd.decide && step) begin
        count    <= '0;
        wp       <= '0;
        integral <= '0;
      end
      if (cmd.med_read) begin
        count <= c1;
        wp    <= (wp == AW'(WINDOW - 1)) ? '0 : wp + AW'(1);
      end
      if (cmd.acc) begin
        if (sum > lim) begin
          integral <= 32'(lim);
        end else if (sum < -lim) begin
          integral <= 32'(-lim);
        end else begin
          integral <= 32'(sum);
        end
      end
    end
  end

  // item capture, scans and arithmetic
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      off <= meas_offset;
      ivl <= interval_mult;
    end
    if (cmd.decide) begin
      step_flag <= step;
      rd        <= '0;
      rvld      <= 1'b0;
      found     <= 1'b0;
    end
    if (cmd.rm_scan) begin
      rvld <= (rd < IW'(WINDOW));
      di   <= rd[AW-1:0];
      if (rd < IW'(WINDOW)) begin
        rd <= rd + IW'(1);
      end
      // first copy of the oldest sample is dropped, later entries slide down
      if (rvld && !found && (srd == old)) begin
        found <= 1'b1;
      end
    end
    if (cmd.ins_start) begin
      rk   <= IW'(c) - IW'(1);
      ivld <= 1'b0;
    end
    if (cmd.ins_scan) begin
      ivld <= !rk[IW-1];
      dk   <= rk[AW-1:0];
      if (!rk[IW-1]) begin
        rk <= rk - IW'(1);
      end
    end
    if (cmd.mul) begin
      p    <= mi >>> prop_sh;
      prod <= 49'(mi >>> integ_sh) * 49'($signed({1'b0, ivl}));
    end
    if (cmd.load_out) begin
      action       <= step_flag ? cspm_pkg::ACTION_STEP : cspm_pkg::ACTION_SLEW;
      step_amount  <= step_flag ? $signed(off) : 64'sd0;
      freq_adj_ppb <= step_flag ? 32'sd0 : sat;
    end
  end

endmodule

### rtl/core/clock_servo_pi_median_core.sv
// ----------------------------------------------------------------------------
// clock_servo_pi_median_core
// PI clock servo with a sliding median pre-filter over the offset samples.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries one offset measurement and its
// update interval; output channel (out_valid/out_ready) returns one result
// per item: a step order with the full offset, or a slew with a ppb value.
// Items are handled one at a time. An offset above the step threshold
// skips the window and the PI law. A slew item walks the sorted window
// in RAM one entry per cycle through the single read port: only the
// insertion pass while the window fills, and a drop pass for the oldest
// sample before it once the window is full. The result sits in an output
// register; in_ready returns the cycle after it is loaded, so a new item
// is taken while the receiver stalls. A second finished result waits in
// the sequencer until the register frees up. Reset restores the register
// defaults and clears integral, sample count and ring pointer; the window
// RAMs are not cleared and need no clearing. Configuration writes take
// effect at once. The user must make them while idle; no check enforces it.
// ----------------------------------------------------------------------------
module clock_servo_pi_median_core #(
  parameter int WINDOW = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [63:0]              meas_offset,
  input  logic [15:0]                     interval_mult,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            action,
  output logic signed [63:0]              step_amount,
  output logic signed [31:0]              freq_adj_ppb,
  input  logic                            cfg_we,
  input  logic [cspm_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [cspm_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  cspm_pkg::cmd_t cmd;
  cspm_pkg::sts_t sts;

  cspm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  cspm_dp #(.WINDOW(WINDOW)) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_we        (cfg_we),
    .cfg_idx       (cfg_idx),
    .cfg_wdata     (cfg_wdata),
    .meas_offset   (meas_offset),
    .interval_mult (interval_mult),
    .action        (action),
    .step_amount   (step_amount),
    .freq_adj_ppb  (freq_adj_ppb)
  );

`ifndef ASSERT_OFF
  // one item in flight: ready drops right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while an item is in progress");

  a_step_no_freq: assert property (@(posedge clk) disable iff (rst)
    out_valid && (action == cspm_pkg::ACTION_STEP) |-> freq_adj_ppb == 32'sd0)
    else $error("step result carries a frequency adjustment");

  a_slew_no_step: assert property (@(posedge clk) disable iff (rst)
    out_valid && (action == cspm_pkg::ACTION_SLEW) |-> step_amount == 64'sd0)
    else $error("slew result carries a step offset");
`endif

endmodule
